// File: design/ppb_pkg.sv
package ppb_pkg;

  localparam int CAP_W  = 7;
  localparam int DATA_W = 32;
  localparam int PRIO_W = 32;
  localparam int CNT_W  = 32;

  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [1:0] CNT_PRI_HIT  = 2'd0;
  localparam logic [1:0] CNT_PRI_MISS = 2'd1;
  localparam logic [1:0] CNT_SEC_HIT  = 2'd2;
  localparam logic [1:0] CNT_SEC_MISS = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_e;

endpackage

// File: design/ppb_ram.sv
module ppb_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/ppb_cfg.sv
module ppb_cfg #(
  parameter int CAPACITY = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [ppb_pkg::DATA_W-1:0]    pwdata,
  output logic [ppb_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output logic [ppb_pkg::CAP_W-1:0]     capacity_o
);

  localparam int CntW   = $clog2(CAPACITY + 1);
  localparam int CmpW   = (CntW > ppb_pkg::CAP_W) ? CntW : ppb_pkg::CAP_W;
  localparam int CapRst = (CAPACITY < 64) ? CAPACITY : 64;

  logic [ppb_pkg::CAP_W-1:0] cap_q, cap_d;
  logic [ppb_pkg::CAP_W-1:0] wval;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == ppb_pkg::REG_CAPACITY);
  assign wval   = pwdata[ppb_pkg::CAP_W-1:0];

  always_comb begin
    cap_d = cap_q;
    if (wr_en) begin
      if (wval == '0) begin
        cap_d = ppb_pkg::CAP_W'(1);
      end else if (CmpW'(wval) > CmpW'(CAPACITY)) begin
        cap_d = ppb_pkg::CAP_W'(CAPACITY);
      end else begin
        cap_d = wval;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= ppb_pkg::CAP_W'(CapRst);
    end else begin
      cap_q <= cap_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == ppb_pkg::REG_CAPACITY) begin
      prdata = ppb_pkg::DATA_W'(cap_q);
    end
  end

  assign capacity_o = cap_q;

endmodule

// File: design/priority_page_buffer_core.sv
// Channel | Direction | Handshake               | Beat payload
// in      | input     | in_valid_i / in_ready_o   | page_number_i, page_kind_i, priority_req_i
// out     | output    | out_valid_o / out_ready_i | hit_o, four hit/miss counters
// cfg     | input     | psel/penable/pwrite       | capacity_in_use at byte address 0
//
// A miss passes through ST_IDLE (accept), ST_SCAN and ST_WRITE; ST_SCAN sweeps one occupied
// slot per cycle through the single read port of the slot memory, skipped when none is occupied.
// A hit on slot k ends the sweep there.
// Reset clears control, occupancy, access clock and counters; the slot memory is not cleared.
// A result waits in the output register; the next access may sweep meanwhile and stalls
// only at its write cycle until the waiting result is taken.
module priority_page_buffer_core #(
  parameter int CAPACITY  = 64,
  parameter int PAGE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [ppb_pkg::DATA_W-1:0]   pwdata,
  output logic [ppb_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [31:0]                  page_number_i,
  input  logic                         page_kind_i,
  input  logic signed [32:0]           priority_req_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o,
  output logic [ppb_pkg::CNT_W-1:0]    primary_hits_o,
  output logic [ppb_pkg::CNT_W-1:0]    primary_misses_o,
  output logic [ppb_pkg::CNT_W-1:0]    secondary_hits_o,
  output logic [ppb_pkg::CNT_W-1:0]    secondary_misses_o
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int OccW  = $clog2(CAPACITY + 1);
  localparam int CmpW  = (OccW > ppb_pkg::CAP_W) ? OccW : ppb_pkg::CAP_W;
  localparam int TagW  = PAGE_BITS + 1;
  localparam int PW    = ppb_pkg::PRIO_W;
  localparam int MemW  = TagW + PW;

  logic [ppb_pkg::CAP_W-1:0] capacity;

  ppb_pkg::state_e state_q, state_d;
  logic [TagW-1:0]           tag_q, tag_d;
  logic                      kind_q, kind_d;
  logic [PW-1:0]             prio_q, prio_d;
  logic [PW-1:0]             clock_q, clock_d;
  logic [OccW-1:0]           occ_q, occ_d;
  logic [AW-1:0]             idx_q, idx_d;
  logic                      found_q, found_d;
  logic [AW-1:0]             best_idx_q, best_idx_d;
  logic [PW-1:0]             best_prio_q, best_prio_d;
  logic [3:0][ppb_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      hit_q, hit_d;
  logic                      out_valid_q, out_valid_d;

  logic                      in_beat;
  logic                      we;
  logic [AW-1:0]             waddr;
  logic [AW-1:0]             raddr;
  logic [MemW-1:0]           rdata;
  logic [TagW-1:0]           rd_tag;
  logic [PW-1:0]             rd_prio;
  logic                      match;
  logic                      last;
  logic                      better;
  logic                      free_slot;
  logic [1:0]                cnt_idx;

  ppb_cfg #(
    .CAPACITY (CAPACITY)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .capacity_o (capacity)
  );

  ppb_ram #(
    .WIDTH (MemW),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({tag_q, prio_q}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_ready_o = (state_q == ppb_pkg::ST_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;

  assign rd_tag  = rdata[MemW-1:PW];
  assign rd_prio = rdata[PW-1:0];
  assign match   = (rd_tag == tag_q);
  assign last    = ((OccW'(idx_q) + OccW'(1)) == occ_q);
  assign better  = (idx_q == '0) || (rd_prio < best_prio_q);

  assign free_slot = !found_q && (CmpW'(occ_q) < CmpW'(capacity));
  assign cnt_idx   = {kind_q, !found_q};

  always_comb begin
    raddr = '0;
    if (state_q == ppb_pkg::ST_SCAN && !match && !last) begin
      raddr = idx_q + AW'(1);
    end
  end

  always_comb begin
    waddr = best_idx_q;
    if (found_q) begin
      waddr = idx_q;
    end else if (free_slot) begin
      waddr = AW'(occ_q);
    end
  end

  always_comb begin
    state_d     = state_q;
    tag_d       = tag_q;
    kind_d      = kind_q;
    prio_d      = prio_q;
    clock_d     = clock_q;
    occ_d       = occ_q;
    idx_d       = idx_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_prio_d = best_prio_q;
    cnt_d       = cnt_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    we          = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ppb_pkg::ST_IDLE: begin
        if (in_beat) begin
          tag_d   = {page_kind_i, PAGE_BITS'(page_number_i)};
          kind_d  = page_kind_i;
          idx_d   = '0;
          found_d = 1'b0;
          if (priority_req_i[32]) begin
            clock_d = clock_q + PW'(1);
            prio_d  = clock_q + PW'(1);
          end else begin
            prio_d  = priority_req_i[PW-1:0];
          end
          state_d = (occ_q == '0) ? ppb_pkg::ST_WRITE : ppb_pkg::ST_SCAN;
        end
      end
      ppb_pkg::ST_SCAN: begin
        if (match) begin
          found_d = 1'b1;
          state_d = ppb_pkg::ST_WRITE;
        end else begin
          if (better) begin
            best_idx_d  = idx_q;
            best_prio_d = rd_prio;
          end
          if (last) begin
            state_d = ppb_pkg::ST_WRITE;
          end else begin
            idx_d = idx_q + AW'(1);
          end
        end
      end
      ppb_pkg::ST_WRITE: begin
        if (!out_valid_q || out_ready_i) begin
          we               = 1'b1;
          cnt_d[cnt_idx]   = cnt_q[cnt_idx] + ppb_pkg::CNT_W'(1);
          hit_d            = found_q;
          out_valid_d      = 1'b1;
          if (free_slot) begin
            occ_d = occ_q + OccW'(1);
          end
          state_d = ppb_pkg::ST_IDLE;
        end
      end
      default: state_d = ppb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ppb_pkg::ST_IDLE;
      clock_q     <= '0;
      occ_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clock_q     <= clock_d;
      occ_q       <= occ_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q       <= tag_d;
    kind_q      <= kind_d;
    prio_q      <= prio_d;
    idx_q       <= idx_d;
    found_q     <= found_d;
    best_idx_q  <= best_idx_d;
    best_prio_q <= best_prio_d;
    hit_q       <= hit_d;
  end

  assign out_valid_o        = out_valid_q;
  assign hit_o              = hit_q;
  assign primary_hits_o     = cnt_q[ppb_pkg::CNT_PRI_HIT];
  assign primary_misses_o   = cnt_q[ppb_pkg::CNT_PRI_MISS];
  assign secondary_hits_o   = cnt_q[ppb_pkg::CNT_SEC_HIT];
  assign secondary_misses_o = cnt_q[ppb_pkg::CNT_SEC_MISS];

endmodule

// File: design/ppb_checker.sv
module ppb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        hit_o,
  input logic [31:0] primary_hits_o,
  input logic [31:0] primary_misses_o,
  input logic [31:0] secondary_hits_o,
  input logic [31:0] secondary_misses_o
);

  logic new_result;
  logic hit_moved;
  logic [3:0] moved;

  logic [31:0] pri_hits_q;
  logic [31:0] pri_misses_q;
  logic [31:0] sec_hits_q;
  logic [31:0] sec_misses_q;
  logic        out_valid_q;
  logic        out_ready_q;

  always_ff @(posedge clk_i) begin
    pri_hits_q   <= primary_hits_o;
    pri_misses_q <= primary_misses_o;
    sec_hits_q   <= secondary_hits_o;
    sec_misses_q <= secondary_misses_o;
    out_valid_q  <= out_valid_o;
    out_ready_q  <= out_ready_i;
  end

  assign moved = {primary_hits_o != pri_hits_q,
                  primary_misses_o != pri_misses_q,
                  secondary_hits_o != sec_hits_q,
                  secondary_misses_o != sec_misses_q};
  assign hit_moved  = moved[3] || moved[1];
  assign new_result = out_valid_o && (!out_valid_q || out_ready_q);

  ap_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while an access is in flight");

  ap_one_count_per_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    new_result |-> ($countones(moved) == 1))
    else $error("result beat does not move exactly one counter");

  ap_hit_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    new_result |-> (hit_o == hit_moved))
    else $error("hit flag disagrees with the counter that moved");

  ap_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(hit_o)
      && $stable(primary_hits_o) && $stable(secondary_misses_o)))
    else $error("stalled result beat changed");

endmodule

bind priority_page_buffer_core ppb_checker u_ppb_checker (.*);
